/* design/tlmn_pkg.sv */
package tlmn_pkg;

    // Lifecycle states of one track
    typedef enum logic [1:0] {
        ST_TENTATIVE = 2'd0,
        ST_CONFIRMED = 2'd1,
        ST_COASTING  = 2'd2,
        ST_DELETED   = 2'd3
    } life_state_t;

    // Event codes carried by op
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_HIT   = 2'd1;
    localparam logic [1:0] OP_MISS  = 2'd2;

    // Register indexes, byte address 4 * index
    localparam logic [2:0] REG_HIT_NEED       = 3'd0;
    localparam logic [2:0] REG_WIN_LEN        = 3'd1;
    localparam logic [2:0] REG_COAST_LIMIT    = 3'd2;
    localparam logic [2:0] REG_QUALITY_ENABLE = 3'd3;
    localparam logic [2:0] REG_QUALITY_SPAN   = 3'd4;
    localparam logic [2:0] REG_MIN_HIT_RATIO  = 3'd5;
    localparam logic [2:0] REG_MAX_NIS        = 3'd6;
    localparam logic [2:0] REG_NIS_ALPHA      = 3'd7;

    localparam int ADDR_W = 5;

    // Configuration registers
    typedef struct packed {
        logic [5:0]  hit_need;
        logic [5:0]  win_len;
        logic [7:0]  coast_limit;
        logic        quality_enable;
        logic [5:0]  quality_span;
        logic [8:0]  min_hit_ratio_q8;
        logic [15:0] max_nis_q8;
        logic [15:0] nis_alpha_q16;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        hit_need:         6'd3,
        win_len:          6'd5,
        coast_limit:      8'd10,
        quality_enable:   1'b0,
        quality_span:     6'd32,
        min_hit_ratio_q8: 9'd128,
        max_nis_q8:       16'd2560,
        nis_alpha_q16:    16'd6554
    };

    // NIS average after reset or start: 2.0 in Q8.8
    localparam logic [15:0] NIS_RESET = 16'd512;
    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

endpackage

/* design/tlmn_cfg.sv */
module tlmn_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tlmn_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output tlmn_pkg::cfg_t              cfg
);
    import tlmn_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    // Decode the write transaction into the addressed register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_HIT_NEED:       cfg_next.hit_need         = pwdata[5:0];
                REG_WIN_LEN:        cfg_next.win_len          = pwdata[5:0];
                REG_COAST_LIMIT:    cfg_next.coast_limit      = pwdata[7:0];
                REG_QUALITY_ENABLE: cfg_next.quality_enable   = pwdata[0];
                REG_QUALITY_SPAN:   cfg_next.quality_span     = pwdata[5:0];
                REG_MIN_HIT_RATIO:  cfg_next.min_hit_ratio_q8 = pwdata[8:0];
                REG_MAX_NIS:        cfg_next.max_nis_q8       = pwdata[15:0];
                REG_NIS_ALPHA:      cfg_next.nis_alpha_q16    = pwdata[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read back the addressed register
    always_comb
    begin
        unique case (reg_idx)
            REG_HIT_NEED:       prdata = 32'(cfg_reg.hit_need);
            REG_WIN_LEN:        prdata = 32'(cfg_reg.win_len);
            REG_COAST_LIMIT:    prdata = 32'(cfg_reg.coast_limit);
            REG_QUALITY_ENABLE: prdata = 32'(cfg_reg.quality_enable);
            REG_QUALITY_SPAN:   prdata = 32'(cfg_reg.quality_span);
            REG_MIN_HIT_RATIO:  prdata = 32'(cfg_reg.min_hit_ratio_q8);
            REG_MAX_NIS:        prdata = 32'(cfg_reg.max_nis_q8);
            REG_NIS_ALPHA:      prdata = 32'(cfg_reg.nis_alpha_q16);
            default:            prdata = '0;
        endcase
    end

endmodule

/* design/tlmn_ema.sv */
module tlmn_ema (
    input  logic [15:0] avg,
    input  logic [15:0] nis,
    input  logic [15:0] alpha,
    output logic [15:0] avg_next
);
    logic signed [16:0] diff;
    logic signed [33:0] prod;
    logic signed [33:0] prod_rnd;
    logic signed [17:0] delta;
    logic signed [18:0] sum;

    // Step toward the new NIS by alpha, Q8.24 product rounded half up to Q8.8
    assign diff     = $signed({1'b0, nis}) - $signed({1'b0, avg});
    assign prod     = $signed({18'd0, alpha}) * $signed({{17{diff[16]}}, diff});
    assign prod_rnd = prod + 34'sd32768;
    assign delta    = prod_rnd[33:16];
    assign sum      = $signed({3'b000, avg}) + $signed({delta[17], delta});

    // Clamp to the unsigned Q8.8 range
    always_comb
    begin
        if (sum[18])
        begin
            avg_next = 16'd0;
        end
        else if (sum[17:16] != 2'b00)
        begin
            avg_next = 16'hFFFF;
        end
        else
        begin
            avg_next = sum[15:0];
        end
    end

endmodule

/* design/tlmn_update.sv */
module tlmn_update #(
    parameter int HISTORY_BITS = 32
) (
    input  tlmn_pkg::cfg_t           cfg,
    input  logic [1:0]               op,
    input  logic [15:0]              nis,
    input  tlmn_pkg::life_state_t    state,
    input  logic [HISTORY_BITS-1:0]  hist,
    input  logic [15:0]              age,
    input  logic [15:0]              miss,
    input  logic [15:0]              avg,
    output tlmn_pkg::life_state_t    state_next,
    output logic [HISTORY_BITS-1:0]  hist_next,
    output logic [15:0]              age_next,
    output logic [15:0]              miss_next,
    output logic [15:0]              avg_next,
    output logic [5:0]               win_hits
);
    import tlmn_pkg::*;

    localparam int CNT_W   = $clog2(HISTORY_BITS + 1);
    localparam int RATIO_W = 9 + CNT_W;

    function automatic logic [CNT_W-1:0] clamp_win(input logic [5:0] n);
        logic [CNT_W-1:0] r;
        if (n == 6'd0)
            r = CNT_W'(1);
        else if (32'(n) > 32'(HISTORY_BITS))
            r = CNT_W'(HISTORY_BITS);
        else
            r = CNT_W'(n);
        return r;
    endfunction

    function automatic logic [HISTORY_BITS-1:0] low_mask(input logic [CNT_W-1:0] n);
        logic [HISTORY_BITS-1:0] m;
        for (int i = 0; i < HISTORY_BITS; i++)
            m[i] = (32'(i) < 32'(n));
        return m;
    endfunction

    function automatic logic [CNT_W-1:0] count_ones(input logic [HISTORY_BITS-1:0] v);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < HISTORY_BITS; i++)
            c = c + CNT_W'(v[i]);
        return c;
    endfunction

    logic              live;
    logic              event_live;
    logic [15:0]       age_inc;
    logic [15:0]       miss_inc;
    logic [15:0]       ema_avg;
    logic [CNT_W-1:0]  win_cnt;
    logic [CNT_W-1:0]  q_clamp;
    logic [CNT_W-1:0]  q_span;
    logic [CNT_W-1:0]  span_cnt;
    logic              ratio_bad;
    logic              quality_bad;
    life_state_t       trans_state;

    tlmn_ema u_ema (
        .avg      (avg),
        .nis      (nis),
        .alpha    (cfg.nis_alpha_q16),
        .avg_next (ema_avg)
    );

    assign live       = (state != ST_DELETED);
    assign event_live = live && ((op == OP_HIT) || (op == OP_MISS));
    assign age_inc    = (age == COUNT_MAX) ? age : age + 16'd1;
    assign miss_inc   = (miss == COUNT_MAX) ? miss : miss + 16'd1;

    // Advance history, counters and NIS average for the event
    always_comb
    begin
        hist_next = hist;
        age_next  = age;
        miss_next = miss;
        avg_next  = avg;
        case (op)
            OP_START:
            begin
                hist_next = HISTORY_BITS'(1);
                age_next  = 16'd1;
                miss_next = 16'd0;
                avg_next  = NIS_RESET;
            end
            OP_HIT:
            begin
                if (live)
                begin
                    hist_next = {hist[HISTORY_BITS-2:0], 1'b1};
                    age_next  = age_inc;
                    miss_next = 16'd0;
                    avg_next  = ema_avg;
                end
            end
            OP_MISS:
            begin
                if (live)
                begin
                    hist_next = {hist[HISTORY_BITS-2:0], 1'b0};
                    age_next  = age_inc;
                    miss_next = miss_inc;
                end
            end
            default:
            begin
                hist_next = hist;
            end
        endcase
    end

    // Count hits in the confirmation window and the quality span
    assign win_cnt  = count_ones(hist_next & low_mask(clamp_win(cfg.win_len)));
    assign win_hits = 6'(win_cnt);
    assign q_clamp  = clamp_win(cfg.quality_span);
    assign q_span   = (age_next < 16'(q_clamp)) ? CNT_W'(age_next) : q_clamp;
    assign span_cnt = count_ones(hist_next & low_mask(q_span));

    assign ratio_bad = RATIO_W'({span_cnt, 8'd0})
                     < RATIO_W'(cfg.min_hit_ratio_q8) * RATIO_W'(q_span);

    // Lifecycle transition for the event
    always_comb
    begin
        trans_state = state;
        case (op)
            OP_START:
            begin
                trans_state = ST_TENTATIVE;
            end
            OP_HIT:
            begin
                if (state == ST_TENTATIVE)
                begin
                    if (16'(win_cnt) >= 16'(cfg.hit_need))
                        trans_state = ST_CONFIRMED;
                    else if (age_next >= 16'(cfg.win_len))
                        trans_state = ST_DELETED;
                end
                else if (state == ST_COASTING)
                begin
                    trans_state = ST_CONFIRMED;
                end
            end
            OP_MISS:
            begin
                if (state == ST_TENTATIVE)
                begin
                    if (age_next >= 16'(cfg.win_len))
                        trans_state = ST_DELETED;
                end
                else if (state == ST_CONFIRMED)
                begin
                    trans_state = ST_COASTING;
                end
                else if (state == ST_COASTING)
                begin
                    if (miss_next >= 16'(cfg.coast_limit))
                        trans_state = ST_DELETED;
                end
            end
            default:
            begin
                trans_state = state;
            end
        endcase
    end

    // When quality checks are enabled, drop a confirmed or coasting track that fails the hit-ratio or NIS test
    assign quality_bad = event_live && cfg.quality_enable
                       && ((trans_state == ST_CONFIRMED) || (trans_state == ST_COASTING))
                       && (age_next >= 16'(cfg.quality_span))
                       && (ratio_bad || (avg_next > cfg.max_nis_q8));

    assign state_next = quality_bad ? ST_DELETED : trans_state;

endmodule

/* design/track_lifecycle_m_of_n_core.sv */
// Track lifecycle with M-of-N confirmation for one target track.
//
// Input channel (item_valid / item_stall): one event per frame, op selects
// start, hit or miss, nis_q8 carries the NIS of a hit. Output channel
// (result_valid / result_stall): exactly one result per event, the track
// after that event (state, age, miss run, window hits, smoothed NIS).
// Configuration goes through the APB port at byte address 4 * index; the user
// writes it only while no event is in flight; the block does not enforce it.
//
// An accepted event sits in the input register; once the result register is
// free, a single combinational pass updates the track registers and loads
// the result register, which drives the output. One event is accepted
// every cycle while the receiver does not stall, and the next event sees
// the new track.
// When the receiver stalls, the result register holds and the input
// register absorbs one more event before item_stall rises.
// Reset leaves the track deleted, the history and counters at zero, the
// NIS average at 2.0 and the registers at their default values.
module track_lifecycle_m_of_n_core #(
    parameter int HISTORY_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tlmn_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        item_valid,
    output logic                        item_stall,
    input  logic [1:0]                  op,
    input  logic [15:0]                 nis_q8,
    output logic                        result_valid,
    input  logic                        result_stall,
    output logic [1:0]                  track_state,
    output logic [15:0]                 track_age,
    output logic [15:0]                 miss_run,
    output logic [5:0]                  window_hits,
    output logic [15:0]                 nis_smoothed
);
    import tlmn_pkg::*;

    cfg_t                    cfg;

    // Input register
    logic                    in_vld_reg;
    logic [1:0]              op_reg;
    logic [15:0]             nis_reg;

    // Track registers
    life_state_t             state_reg;
    logic [HISTORY_BITS-1:0] hist_reg;
    logic [15:0]             age_reg;
    logic [15:0]             miss_reg;
    logic [15:0]             avg_reg;

    // Result register
    logic                    out_vld_reg;
    logic [1:0]              res_state_reg;
    logic [15:0]             res_age_reg;
    logic [15:0]             res_miss_reg;
    logic [5:0]              res_hits_reg;
    logic [15:0]             res_avg_reg;

    life_state_t             state_next;
    logic [HISTORY_BITS-1:0] hist_next;
    logic [15:0]             age_next;
    logic [15:0]             miss_next;
    logic [15:0]             avg_next;
    logic [5:0]              hits_next;

    logic                    take;
    logic                    advance;

    tlmn_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tlmn_update #(
        .HISTORY_BITS (HISTORY_BITS)
    ) u_update (
        .cfg        (cfg),
        .op         (op_reg),
        .nis        (nis_reg),
        .state      (state_reg),
        .hist       (hist_reg),
        .age        (age_reg),
        .miss       (miss_reg),
        .avg        (avg_reg),
        .state_next (state_next),
        .hist_next  (hist_next),
        .age_next   (age_next),
        .miss_next  (miss_next),
        .avg_next   (avg_next),
        .win_hits   (hits_next)
    );

    // Move the held event into the result register when it is free
    assign advance    = in_vld_reg && (!out_vld_reg || !result_stall);
    assign item_stall = in_vld_reg && !advance;
    assign take       = item_valid && !item_stall;

    // Hold or load the input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (take)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg  <= op;
            nis_reg <= nis_q8;
        end
    end

    // Update the track once per event
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_DELETED;
            hist_reg  <= '0;
            age_reg   <= 16'd0;
            miss_reg  <= 16'd0;
            avg_reg   <= NIS_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
            hist_reg  <= hist_next;
            age_reg   <= age_next;
            miss_reg  <= miss_next;
            avg_reg   <= avg_next;
        end
    end

    // Hold the result while stalled, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_state_reg <= state_next;
            res_age_reg   <= age_next;
            res_miss_reg  <= miss_next;
            res_hits_reg  <= hits_next;
            res_avg_reg   <= avg_next;
        end
    end

    assign result_valid = out_vld_reg;
    assign track_state  = res_state_reg;
    assign track_age    = res_age_reg;
    assign miss_run     = res_miss_reg;
    assign window_hits  = res_hits_reg;
    assign nis_smoothed = res_avg_reg;

endmodule

/* design/tlmn_checker.sv */
module tlmn_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_stall,
    input logic [1:0]  track_state,
    input logic [15:0] track_age,
    input logic [15:0] miss_run,
    input logic [5:0]  window_hits,
    input logic [15:0] nis_smoothed
);
    import tlmn_pkg::*;

    // Hold a stalled result transaction
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(track_state)
            && $stable(track_age) && $stable(miss_run)
            && $stable(window_hits) && $stable(nis_smoothed))
        else $error("stalled result changed");

    // A confirmed track is only reached by a hit, so no miss run
    a_confirmed_no_miss: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (track_state == ST_CONFIRMED) |-> miss_run == 16'd0)
        else $error("confirmed track with misses");

    // A tentative track dies once its age reaches the window
    a_tentative_age: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (track_state == ST_TENTATIVE) |-> track_age <= 16'd63)
        else $error("tentative track outlived its window");

    // The start frame counts as a hit, so misses stay below the age
    a_tentative_misses: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (track_state == ST_TENTATIVE) |-> miss_run < track_age)
        else $error("tentative miss run not below age");

endmodule

bind track_lifecycle_m_of_n_core tlmn_checker u_tlmn_checker (.*);
